>>> rtl/rbs_pkg.sv
// Shared widths, reset values and register indexes for the resampler block size unit.
package rbs_pkg;

  localparam int unsigned RateBits = 24;
  localparam int unsigned SizeBits = 13;
  localparam int unsigned ProdBits = RateBits + SizeBits;
  localparam int unsigned DivBits  = ProdBits;
  localparam int unsigned SumBits  = ProdBits + 1;
  localparam int unsigned OutBits  = 24;
  localparam int unsigned CntBits  = $clog2(DivBits + 1);

  localparam logic [RateBits-1:0] BaseRateReset = RateBits'(48000);
  localparam logic [SizeBits-1:0] BaseSizeReset = SizeBits'(64);
  localparam logic [OutBits-1:0]  OutMax        = {OutBits{1'b1}};

  localparam logic CfgBaseRate = 1'b0;
  localparam logic CfgBaseSize = 1'b1;

  typedef logic [RateBits-1:0] rate_t;

endpackage

>>> rtl/resampler_block_size_top.sv
// Block size from sample rate: scaled size rounded up to the polyphase factor.
//
//   channel  | signals                                   | dir
//   ---------+-------------------------------------------+-----
//   input    | in_valid_i, in_ready_o, sample_rate_i     | in
//   result   | out_valid_o, out_ready_i, block_size_o    | out
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// One shift-subtract divider, one quotient or remainder bit per cycle, does all work:
// scaled size (37 steps), each Euclid remainder (24 steps plus 1), factor (24 steps) and
// rounding remainder (37 steps). Reset is asynchronous, active low, and restores
// base rate 48000 and base size 64. Input is taken only while the unit is idle; a result
// waits in the output register and a second finished result holds the unit until it leaves.
module resampler_block_size_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rbs_pkg::RateBits-1:0]  sample_rate_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rbs_pkg::OutBits-1:0]   block_size_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rbs_pkg::RateBits-1:0]  cfg_data_i
);

  localparam int unsigned RW = rbs_pkg::RateBits;
  localparam int unsigned DW = rbs_pkg::DivBits;
  localparam int unsigned CW = rbs_pkg::CntBits;
  localparam int unsigned PadW = DW - RW;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SNat  = 3'd2;
  localparam logic [2:0] SGcd  = 3'd3;
  localparam logic [2:0] SGdiv = 3'd4;
  localparam logic [2:0] SMdiv = 3'd5;
  localparam logic [2:0] SRdiv = 3'd6;
  localparam logic [2:0] SOut  = 3'd7;

  logic [2:0] state_q, state_d;
  rbs_pkg::rate_t dsp_rate_q;
  logic [rbs_pkg::SizeBits-1:0] dsp_size_q;
  rbs_pkg::rate_t rate_q, rate_d;
  rbs_pkg::rate_t a_q, a_d, b_q, b_d, m_q, m_d;
  logic [DW-1:0] nat_q, nat_d;
  logic [DW-1:0] num_q, num_d;
  rbs_pkg::rate_t rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [rbs_pkg::OutBits-1:0] res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic [rbs_pkg::OutBits-1:0] out_q, out_d;
  // marks that the rounded sum still has to be formed before the result leaves
  logic res_pending_q, res_pending_d;

  // divider step
  logic [RW:0] trial, diff;
  logic ge, last;
  rbs_pkg::rate_t rem_next;
  logic [DW-1:0] num_next;
  logic [rbs_pkg::ProdBits-1:0] prod;
  logic [rbs_pkg::SumBits-1:0] sum;

  function automatic logic [rbs_pkg::OutBits-1:0] sat(input logic [rbs_pkg::SumBits-1:0] v);
    if (v > rbs_pkg::SumBits'(rbs_pkg::OutMax)) begin
      sat = rbs_pkg::OutMax;
    end else begin
      sat = v[rbs_pkg::OutBits-1:0];
    end
  endfunction

  assign trial    = {rem_q, num_q[DW-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = (trial >= {1'b0, den_q});
  assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
  assign num_next = {num_q[DW-2:0], ge};
  assign last     = (cnt_q == CW'(1));
  assign prod     = dsp_size_q * rate_q;
  assign sum      = (rem_q == '0) ? {1'b0, nat_q}
                                  : {1'b0, nat_q} + rbs_pkg::SumBits'(m_q - rem_q);

  always_comb begin
    state_d     = state_q;
    rate_d      = rate_q;
    a_d         = a_q;
    b_d         = b_q;
    m_d         = m_q;
    nat_d       = nat_q;
    num_d       = num_q;
    rem_d       = rem_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          rate_d  = sample_rate_i;
          state_d = SMul;
        end
      end
      SMul: begin
        a_d = rate_q;
        b_d = dsp_rate_q;
        if (dsp_rate_q == '0) begin
          nat_d   = '0;
          state_d = SGcd;
        end else begin
          num_d   = prod;
          den_d   = dsp_rate_q;
          rem_d   = '0;
          cnt_d   = CW'(DW);
          state_d = SNat;
        end
      end
      SNat: begin
        num_d = num_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          nat_d   = num_next;
          state_d = SGcd;
        end
      end
      SGcd: begin
        rem_d = '0;
        cnt_d = CW'(RW);
        if (b_q == '0) begin
          if (a_q == '0) begin
            // zero factor: keep the scaled size
            res_d   = sat({1'b0, nat_q});
            state_d = SOut;
          end else begin
            num_d   = {rate_q, {PadW{1'b0}}};
            den_d   = a_q;
            state_d = SMdiv;
          end
        end else begin
          num_d   = {a_q, {PadW{1'b0}}};
          den_d   = b_q;
          state_d = SGdiv;
        end
      end
      SGdiv: begin
        num_d = num_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          a_d     = b_q;
          b_d     = rem_next;
          state_d = SGcd;
        end
      end
      SMdiv: begin
        num_d = num_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          if (num_next[RW-1:0] <= rbs_pkg::RateBits'(1)) begin
            res_d   = sat({1'b0, nat_q});
            state_d = SOut;
          end else begin
            m_d     = num_next[RW-1:0];
            num_d   = nat_q;
            den_d   = num_next[RW-1:0];
            rem_d   = '0;
            cnt_d   = CW'(DW);
            state_d = SRdiv;
          end
        end
      end
      SRdiv: begin
        num_d = num_next;
        rem_d = rem_next;
        cnt_d = cnt_q - CW'(1);
        if (last) begin
          state_d = SOut;
          cnt_d   = '0;
        end
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // form the rounded size in the cycle after the last divide step, then hold in SOut
    if (state_q == SOut && res_pending_q) begin
      res_d       = sat(sum);
      out_valid_d = out_valid_q && !out_ready_i;
      out_d       = out_q;
      state_d     = SOut;
    end
  end

  always_comb begin
    res_pending_d = res_pending_q;
    if (state_q == SRdiv && last) begin
      res_pending_d = 1'b1;
    end else if (state_q == SOut) begin
      res_pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      out_valid_q   <= 1'b0;
      res_pending_q <= 1'b0;
      cnt_q         <= '0;
      dsp_rate_q    <= rbs_pkg::BaseRateReset;
      dsp_size_q    <= rbs_pkg::BaseSizeReset;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      res_pending_q <= res_pending_d;
      cnt_q         <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbs_pkg::CfgBaseRate: dsp_rate_q <= cfg_data_i;
          rbs_pkg::CfgBaseSize: dsp_size_q <= cfg_data_i[rbs_pkg::SizeBits-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    a_q    <= a_d;
    b_q    <= b_d;
    m_q    <= m_d;
    nat_q  <= nat_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_ready_o   = (state_q == SIdle);
  assign out_valid_o  = out_valid_q;
  assign block_size_o = out_q;

endmodule
